// ----- rtl/core/ffra_pkg.sv -----
// Shared types and constants for the first-fit region allocator.
`default_nettype none

package ffra_pkg;

    // Field widths of the request and reply words
    localparam int SIZE_W    = 28;
    localparam int ADDR_W    = 27;
    localparam int REG_W     = 28;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    localparam int TABLE_ENTRIES_DEF = 64;

    // Managed memory size and its last byte address
    localparam logic [REG_W-1:0] MEM_BYTES = 28'd134217728;
    localparam logic [REG_W-1:0] MEM_TOP   = MEM_BYTES - 28'd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    // One table entry: free region [start, last], inclusive
    typedef struct packed {
        logic             valid;
        logic [REG_W-1:0] start;
        logic [REG_W-1:0] last;
    } region_t;

    localparam region_t ENTRY0_RESET = '{valid: 1'b1, start: '0, last: MEM_TOP};

    // Reply handed from the sequencer to the output register
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] addr;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/first_fit_region_allocator_core.sv -----
// Top level of the first-fit region allocator with coalescing free.
//
//  channel  dir  word fields (lowest bit up)                      handshake
//  -------  ---  -----------------------------------------------  ------------------
//  s_       in   tdata: req_size[27:0], free_address[54:28], pad   s_tvalid/s_tready
//                tuser: cmd (0 alloc, 1 free)
//  m_       out  tdata: alloc_address[26:0], pad                   m_tvalid/m_tready
//                tuser: status (0 done, 1 no fit, 2 table full)
//
// One request is in work at a time. Each request reads the region table one
// entry per cycle through the single read port of the table memory; an
// allocate stops at the first entry that fits, a free reads every entry and
// a free that merges on both sides also clears the right entry. A zero-size
// request, or a free at an address beyond memory, skips the scan.
// After reset a clearing pass writes all TABLE_ENTRIES entries, one a cycle,
// with s_tready low. A stalled reply waits in the output register; the next
// request word is taken as soon as the sequencer has handed its reply over.
`default_nettype none

module first_fit_region_allocator_core #(
    parameter int TABLE_ENTRIES = ffra_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [ffra_pkg::S_TDATA_W-1:0]    s_tdata,  // req_size, free_address, pad
    input  wire                              s_tuser,  // cmd
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [ffra_pkg::M_TDATA_W-1:0]   m_tdata,  // alloc_address, pad
    output logic [1:0]                       m_tuser   // status
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int SW = ffra_pkg::SIZE_W;
    localparam int AW = ffra_pkg::ADDR_W;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    ffra_pkg::region_t    rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    ffra_pkg::region_t    wr_data;
    logic                 res_valid;
    logic                 res_ready;
    ffra_pkg::res_t       res;

    logic                 m_tvalid_reg;
    ffra_pkg::res_t       m_res_reg;

    ffra_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ffra_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_size   (s_tdata[SW-1:0]),
        .in_addr   (s_tdata[SW+AW-1:SW]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Output register: take a reply whenever the slot is empty or draining
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{(ffra_pkg::M_TDATA_W - AW){1'b0}}, m_res_reg.addr};

endmodule

`default_nettype wire

// ----- rtl/core/ffra_table.sv -----
// Region table memory: one write port, one read port, registered read data.
`default_nettype none

module ffra_table #(
    parameter int TABLE_ENTRIES = ffra_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                            clk,
    input  wire                            rd_en,
    input  wire [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    output ffra_pkg::region_t              rd_data,
    input  wire                            wr_en,
    input  wire [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
    input  ffra_pkg::region_t              wr_data
);

    ffra_pkg::region_t mem [TABLE_ENTRIES];
    ffra_pkg::region_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ffra_ctrl.sv -----
// Request sequencer: table clearing, scan, merge and write-back.
`default_nettype none

module ffra_ctrl #(
    parameter int TABLE_ENTRIES = ffra_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire                             in_cmd,
    input  wire [ffra_pkg::SIZE_W-1:0]      in_size,
    input  wire [ffra_pkg::ADDR_W-1:0]      in_addr,
    output logic                            res_valid,
    input  wire                             res_ready,
    output ffra_pkg::res_t                  res,
    output logic                            rd_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    input  ffra_pkg::region_t               rd_data,
    output logic                            wr_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
    output ffra_pkg::region_t               wr_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam int W = ffra_pkg::REG_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_MERGE2,
        S_RESULT
    } state_t;

    state_t                       state_reg;
    logic [IDX_W-1:0]             init_idx_reg;
    logic                         cmd_reg;
    logic [ffra_pkg::SIZE_W-1:0]  size_reg;
    logic [ffra_pkg::ADDR_W-1:0]  addr_reg;
    logic [W-1:0]                 top_reg;
    logic [IDX_W-1:0]             iss_idx_reg;
    logic                         iss_end_reg;
    logic [IDX_W-1:0]             chk_idx_reg;
    logic                         chk_vld_reg;
    logic                         left_found_reg;
    logic [IDX_W-1:0]             left_idx_reg;
    logic [W-1:0]                 left_start_reg;
    logic                         right_found_reg;
    logic [IDX_W-1:0]             right_idx_reg;
    logic [W-1:0]                 right_last_reg;
    logic                         slot_found_reg;
    logic [IDX_W-1:0]             slot_idx_reg;
    ffra_pkg::status_t            status_reg;
    logic [ffra_pkg::ADDR_W-1:0]  grant_reg;

    // Request decode on the input word
    logic [W:0]   in_sum;
    logic [W-1:0] in_top;
    logic         in_trivial;

    // Entry checks on the word just read
    logic         ent_live;
    logic [W:0]   ent_len;
    logic         ent_fits;
    logic         ent_left;
    logic         ent_right;
    logic         chk_last;
    logic         both_merge;

    assign in_sum = {2'b00, in_addr} + {1'b0, in_size};
    assign in_top = (in_sum > {1'b0, ffra_pkg::MEM_BYTES}) ? ffra_pkg::MEM_BYTES : in_sum[W-1:0];
    assign in_trivial = (in_cmd == ffra_pkg::CMD_ALLOC)
                        ? (in_size == '0)
                        : ((in_size == '0) || ({1'b0, in_addr} >= ffra_pkg::MEM_BYTES));

    assign ent_live  = rd_data.valid && (rd_data.start <= rd_data.last);
    assign ent_len   = {1'b0, rd_data.last} - {1'b0, rd_data.start} + (W+1)'(1);
    assign ent_fits  = ent_live && (ent_len >= {1'b0, size_reg});
    assign ent_right = rd_data.valid && (rd_data.start == top_reg);
    assign ent_left  = rd_data.valid
                       && (({1'b0, rd_data.last} + (W+1)'(1)) == {2'b00, addr_reg});
    assign chk_last  = (chk_idx_reg == LAST_IDX);
    assign both_merge = left_found_reg && right_found_reg && (left_idx_reg != right_idx_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = '{status: status_reg, addr: grant_reg};

    // Memory port drive
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = iss_idx_reg;
        wr_en   = 1'b0;
        wr_addr = chk_idx_reg;
        wr_data = '0;
        unique case (state_reg)
            S_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = init_idx_reg;
                wr_data = (init_idx_reg == '0) ? ffra_pkg::ENTRY0_RESET : '0;
            end
            S_SCAN:
            begin
                rd_en = !iss_end_reg;
                if (chk_vld_reg && (cmd_reg == ffra_pkg::CMD_ALLOC) && ent_fits)
                begin
                    wr_en   = 1'b1;
                    wr_addr = chk_idx_reg;
                    wr_data = '{valid: (ent_len != {1'b0, size_reg}),
                                start: rd_data.start + size_reg,
                                last:  rd_data.last};
                end
            end
            S_APPLY:
            begin
                if (both_merge)
                begin
                    wr_en   = 1'b1;
                    wr_addr = left_idx_reg;
                    wr_data = '{valid: 1'b1, start: left_start_reg, last: right_last_reg};
                end
                else if (left_found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = left_idx_reg;
                    wr_data = '{valid: 1'b1, start: left_start_reg, last: top_reg - W'(1)};
                end
                else if (right_found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = right_idx_reg;
                    wr_data = '{valid: 1'b1, start: {1'b0, addr_reg}, last: right_last_reg};
                end
                else if (slot_found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot_idx_reg;
                    wr_data = '{valid: 1'b1, start: {1'b0, addr_reg}, last: top_reg - W'(1)};
                end
            end
            S_MERGE2:
            begin
                wr_en   = 1'b1;
                wr_addr = right_idx_reg;
                wr_data = '0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            init_idx_reg    <= '0;
            cmd_reg         <= ffra_pkg::CMD_ALLOC;
            size_reg        <= '0;
            addr_reg        <= '0;
            top_reg         <= '0;
            iss_idx_reg     <= '0;
            iss_end_reg     <= 1'b0;
            chk_idx_reg     <= '0;
            chk_vld_reg     <= 1'b0;
            left_found_reg  <= 1'b0;
            left_idx_reg    <= '0;
            left_start_reg  <= '0;
            right_found_reg <= 1'b0;
            right_idx_reg   <= '0;
            right_last_reg  <= '0;
            slot_found_reg  <= 1'b0;
            slot_idx_reg    <= '0;
            status_reg      <= ffra_pkg::ST_DONE;
            grant_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    init_idx_reg <= init_idx_reg + 1'b1;
                    if (init_idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg         <= in_cmd;
                        size_reg        <= in_size;
                        addr_reg        <= in_addr;
                        top_reg         <= in_top;
                        iss_idx_reg     <= '0;
                        iss_end_reg     <= 1'b0;
                        chk_vld_reg     <= 1'b0;
                        left_found_reg  <= 1'b0;
                        right_found_reg <= 1'b0;
                        slot_found_reg  <= 1'b0;
                        grant_reg       <= '0;
                        status_reg      <= (in_cmd == ffra_pkg::CMD_ALLOC)
                                           ? ffra_pkg::ST_NO_FIT : ffra_pkg::ST_DONE;
                        state_reg       <= in_trivial ? S_RESULT : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // advance the read pointer, hold it on the last entry
                    if (rd_en)
                    begin
                        if (iss_idx_reg == LAST_IDX)
                        begin
                            iss_end_reg <= 1'b1;
                        end
                        else
                        begin
                            iss_idx_reg <= iss_idx_reg + 1'b1;
                        end
                    end
                    chk_vld_reg <= rd_en;
                    chk_idx_reg <= iss_idx_reg;
                    if (chk_vld_reg)
                    begin
                        if (cmd_reg == ffra_pkg::CMD_ALLOC)
                        begin
                            if (ent_fits)
                            begin
                                grant_reg  <= rd_data.start[ffra_pkg::ADDR_W-1:0];
                                status_reg <= ffra_pkg::ST_DONE;
                                state_reg  <= S_RESULT;
                            end
                            else if (chk_last)
                            begin
                                state_reg <= S_RESULT;
                            end
                        end
                        else
                        begin
                            // later neighbor matches win: the highest index is kept
                            if (ent_right)
                            begin
                                right_found_reg <= 1'b1;
                                right_idx_reg   <= chk_idx_reg;
                                right_last_reg  <= rd_data.last;
                            end
                            if (ent_left)
                            begin
                                left_found_reg <= 1'b1;
                                left_idx_reg   <= chk_idx_reg;
                                left_start_reg <= rd_data.start;
                            end
                            if (!rd_data.valid && !slot_found_reg)
                            begin
                                slot_found_reg <= 1'b1;
                                slot_idx_reg   <= chk_idx_reg;
                            end
                            if (chk_last)
                            begin
                                state_reg <= S_APPLY;
                            end
                        end
                    end
                end
                S_APPLY:
                begin
                    if (both_merge)
                    begin
                        state_reg <= S_MERGE2;
                    end
                    else
                    begin
                        if (!left_found_reg && !right_found_reg && !slot_found_reg)
                        begin
                            status_reg <= ffra_pkg::ST_TABLE_FULL;
                        end
                        state_reg <= S_RESULT;
                    end
                end
                S_MERGE2:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ffra_checker.sv -----
// Port-level checks for the first-fit region allocator, bound to the top level.
`default_nettype none

module ffra_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [ffra_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire [1:0]                      m_tuser
);

    // hold a stalled reply word
    a_reply_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("reply word changed while stalled");

    // a failed reply (no fit or table full) carries a zero address
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ffra_pkg::ST_DONE) |-> (m_tdata == '0))
        else $error("non-zero address on a failed reply");

    // one request at a time: never take two words on consecutive edges
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // no reply appears in the cycle right after a request is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("reply appeared without processing time");

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (.*);

`default_nettype wire

// ----- tb/first_fit_region_allocator_core_tb.sv -----
// Self-checking testbench for the first-fit region allocator core.
module first_fit_region_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffra_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    // Receiver hold-off long enough to back the block up into its input.
    localparam int HOLD_CYCLES   = 400;
    // A request and the clearing pass both end well inside the hold-off, which
    // dominates the quiet time. Allow ten times the hold-off.
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int SEGMENT_ITEMS = 350;

    // One request word as it travels on the slave side.
    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] base;
    } region_req_t;

    // A granted block that the stimulus may hand back later.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] len;
    } granted_block_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = CMD_ALLOC;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    // Predicted copy of the region table.
    region_t        free_map [TABLE_ENTRIES];

    region_req_t    pending_reqs[$];     // words waiting for the driver
    res_t           pending_replies[$];  // reply words still owed by the block
    granted_block_t live_blocks[$];      // granted and not yet handed back

    region_req_t    held_req;
    int unsigned    send_gap = 0;
    int unsigned    recv_gap = 0;
    int unsigned    send_idle_max = 6;
    int unsigned    recv_idle_max = 6;
    int unsigned    hold_asks = 0;
    int unsigned    hold_done = 0;
    int unsigned    hold_left = 0;
    int unsigned    quiet_cycles = 0;
    int unsigned    fail_count = 0;

    first_fit_region_allocator_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // First fit: take the lowest valid entry whose inclusive length covers
    // the size, grant its start and move the start up.
    function automatic status_t grant_region(input logic [SIZE_W-1:0] size,
                                             output logic [ADDR_W-1:0] base);
        logic [REG_W:0] span;
        bit             found;
        int             i;
        found = 1'b0;
        base  = '0;
        if (size != '0)
        begin
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (!found && free_map[i].valid && free_map[i].start <= free_map[i].last)
                begin
                    span = {1'b0, free_map[i].last} - {1'b0, free_map[i].start} + 1'b1;
                    if (span >= {1'b0, size})
                    begin
                        found = 1'b1;
                        base  = free_map[i].start[ADDR_W-1:0];
                        free_map[i].start = free_map[i].start + size;
                        // Region used up entirely: drop it
                        if (free_map[i].start > free_map[i].last)
                            free_map[i].valid = 1'b0;
                    end
                end
            end
        end
        return found ? ST_DONE : ST_NO_FIT;
    endfunction

    // Hand a range back: clip at the memory top, merge with the highest
    // matching neighbor on each side, else take the first empty slot.
    function automatic status_t release_range(input logic [ADDR_W-1:0] base,
                                              input logic [SIZE_W-1:0] size);
        logic [REG_W:0] lo;
        logic [REG_W:0] room;
        logic [REG_W:0] len;
        logic [REG_W:0] top;
        logic [REG_W:0] hi;
        int             left;
        int             right;
        int             i;
        bit             placed;
        status_t        st;
        st     = ST_DONE;
        left   = -1;
        right  = -1;
        placed = 1'b0;
        lo     = {2'b00, base};
        if (size != '0 && lo < {1'b0, MEM_BYTES})
        begin
            room = {1'b0, MEM_BYTES} - lo;
            len  = ({1'b0, size} > room) ? room : {1'b0, size};
            top  = lo + len;
            hi   = top - 1'b1;
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (free_map[i].valid)
                begin
                    if ({1'b0, free_map[i].start} == top)
                        right = i;
                    if ({1'b0, free_map[i].last} + 1'b1 == lo)
                        left = i;
                end
            end
            if (left >= 0 && right >= 0 && left != right)
            begin
                // Bridge: left entry swallows the right one
                free_map[left].last = free_map[right].last;
                free_map[right]     = '0;
            end
            else if (left >= 0)
                free_map[left].last = hi[REG_W-1:0];
            else if (right >= 0)
                free_map[right].start = lo[REG_W-1:0];
            else
            begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!placed && !free_map[i].valid)
                    begin
                        free_map[i] = '{valid: 1'b1, start: lo[REG_W-1:0],
                                        last: hi[REG_W-1:0]};
                        placed = 1'b1;
                    end
                end
                if (!placed)
                    st = ST_TABLE_FULL;
            end
        end
        return st;
    endfunction

    // Work out the reply word of one accepted request and queue it.
    function automatic void predict_reply(input region_req_t req);
        res_t              want;
        logic [ADDR_W-1:0] grant;
        grant = '0;
        if (req.cmd == CMD_ALLOC)
        begin
            want.status = grant_region(req.size, grant);
            if (want.status == ST_DONE)
                live_blocks.push_back('{base: grant, len: req.size});
        end
        else
            want.status = release_range(req.base, req.size);
        want.addr = grant;
        pending_replies.push_back(want);
    endfunction

    function automatic int unsigned draw_idle(input int unsigned max_gap);
        return $urandom_range(0, max_gap);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued request words, idle a random number of cycles
    // between them, predict at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= CMD_ALLOC;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_reply(held_req);
            // Hold the word while it is offered and not taken
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    held_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, held_req.base, held_req.size};
                    s_tuser  <= held_req.cmd;
                    send_gap <= draw_idle(send_idle_max);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each reply word against the oldest prediction, then
    // stall a random number of cycles, or for a long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        res_t        want;
        int unsigned gap;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_gap  <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: reply word with none expected: status %0d addr %h",
                                 $realtime, m_tuser, m_tdata);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (m_tuser !== want.status ||
                        m_tdata !== {{(M_TDATA_W-ADDR_W){1'b0}}, want.addr})
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: reply mismatch: status exp %0d got %0d, addr exp %h got %h",
                                     $realtime, want.status, m_tuser,
                                     {{(M_TDATA_W-ADDR_W){1'b0}}, want.addr}, m_tdata);
                    end
                end
            end

            if (hold_left != 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_done != hold_asks)
            begin
                // Start the long back-pressure stretch
                m_tready  <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= hold_asks;
            end
            else if (m_tvalid && m_tready)
            begin
                gap = draw_idle(recv_idle_max);
                recv_gap <= gap;
                m_tready <= (gap == 0);
            end
            else if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= (recv_gap == 1);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("first_fit_region_allocator_core test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_request(input logic cmd, input logic [SIZE_W-1:0] size,
                                 input logic [ADDR_W-1:0] base);
        pending_reqs.push_back('{cmd: cmd, size: size, base: base});
    endtask

    // Sender pause: wait until every word went in and every reply came out.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || pending_replies.size() != 0);
    endtask

    // Mostly allocate and hand back granted blocks; some noise on top.
    task automatic queue_random_request();
        int unsigned       pick;
        int unsigned       idx;
        logic [SIZE_W-1:0] size;
        granted_block_t    blk;
        pick = $urandom_range(0, 99);
        if (pick >= 45 && pick < 85 && live_blocks.size() != 0)
        begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[idx];
            live_blocks.delete(idx);
            queue_request(CMD_FREE, blk.len, blk.base);
        end
        else if (pick >= 85)
        begin
            case (pick % 4)
                0: queue_request(CMD_ALLOC, '0, ADDR_W'($urandom()));
                1: queue_request(CMD_FREE, SIZE_W'($urandom()), ADDR_W'($urandom()));
                2: queue_request(CMD_FREE, '0, ADDR_W'($urandom()));
                default: queue_request(CMD_ALLOC, SIZE_W'($urandom()), ADDR_W'($urandom()));
            endcase
        end
        else
        begin
            // Mostly small sizes, a few that take a large share of memory
            case ($urandom_range(0, 9))
                0, 1, 2, 3: size = SIZE_W'($urandom_range(1, 64));
                4, 5, 6:    size = SIZE_W'($urandom_range(1, 4096));
                7, 8:       size = SIZE_W'($urandom_range(1, 1 << 20));
                default:    size = SIZE_W'($urandom_range(1, 1 << 27));
            endcase
            queue_request(CMD_ALLOC, size, ADDR_W'($urandom()));
        end
    endtask

    initial
    begin
        int             seg;
        int             n;
        granted_block_t snap[$];

        for (n = 0; n < TABLE_ENTRIES; n++)
            free_map[n] = '0;
        free_map[0] = ENTRY0_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: edge sizes, every kind of merge, overlaps.
        queue_request(CMD_ALLOC, '0, '0);                 // zero-size allocate
        queue_request(CMD_FREE, '0, 27'd5);               // zero-size free
        queue_request(CMD_ALLOC, '1, '0);                 // larger than memory
        queue_request(CMD_ALLOC, MEM_BYTES, '0);          // whole memory
        queue_request(CMD_ALLOC, 28'd1, '0);              // nothing left
        queue_request(CMD_FREE, '1, '0);                  // clipped to memory top
        queue_request(CMD_ALLOC, 28'd16, '0);
        queue_request(CMD_ALLOC, 28'd16, '0);
        queue_request(CMD_ALLOC, 28'd16, '0);
        queue_request(CMD_FREE, 28'd16, 27'd16);          // no neighbor, new slot
        queue_request(CMD_FREE, 28'd16, 27'd0);           // merge on the right
        queue_request(CMD_FREE, 28'd16, 27'd32);          // merge on both sides
        queue_request(CMD_FREE, 28'd10, 27'd100);         // overlap, new slot
        queue_request(CMD_ALLOC, 28'd10, '0);             // used up exactly
        queue_request(CMD_FREE, '1, '1);                  // top byte, clipped
        queue_request(CMD_ALLOC, 28'd1, '1);              // grant of the top byte
        queue_request(CMD_FREE, 28'd10, 27'd200);
        queue_request(CMD_FREE, 28'd10, 27'd200);         // double free
        queue_request(CMD_FREE, 28'd5, 27'd210);          // two left matches
        queue_request(CMD_FREE, 28'd10, 27'd190);         // two right matches
        queue_request(CMD_ALLOC, 28'd10, '0);
        queue_request(CMD_ALLOC, 28'd25, '0);
        wait_drained();
        live_blocks.delete();

        // Fragment: carve single bytes, then hand back every other one so
        // that no freed byte has a free neighbor and the table runs full.
        send_idle_max = 0;
        recv_idle_max = 0;
        for (n = 0; n < 150; n++)
            queue_request(CMD_ALLOC, 28'd1, ADDR_W'($urandom()));
        wait_drained();
        snap = live_blocks;
        live_blocks.delete();
        for (n = 0; n < snap.size(); n++)
        begin
            if (n % 2 == 0)
                queue_request(CMD_FREE, snap[n].len, snap[n].base);
            else
                live_blocks.push_back(snap[n]);
        end
        wait_drained();

        // Random segments with different idle patterns on each side.
        for (seg = 0; seg < 4; seg++)
        begin
            send_idle_max = (seg == 0 || seg == 3) ? 6 : 0;
            recv_idle_max = (seg % 2 == 0) ? 6 : 0;
            for (n = 0; n < SEGMENT_ITEMS; n++)
            begin
                while (pending_reqs.size() >= 2)
                    @(negedge clk);
                // Keep offering words while the receiver holds off
                if (seg == 1 && n == 10)
                    hold_asks++;
                queue_random_request();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("first_fit_region_allocator_core test passed");
        else
            $display("first_fit_region_allocator_core test failed");
        $finish;
    end

endmodule
